FILE: rtl/coh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coh_pkg
// Shared types, widths and helpers of the cell orientation histogram.
// ----------------------------------------------------------------------------
package coh_pkg;

    localparam int MAG_W    = 16;  // gradient magnitude, 4 fractional bits
    localparam int CODE_W   = 13;  // orientation code
    localparam int FRAC_W   = 8;   // fraction inside one bin
    localparam int COARSE_W = CODE_W - FRAC_W;
    localparam int WGT_W    = FRAC_W + 1;      // weight 0..256
    localparam int PROD_W   = MAG_W + WGT_W;   // weighted magnitude
    localparam int ACC_W    = 30;  // accumulator, 12 fractional bits
    localparam int IDX_W    = 5;   // bin number on the result stream
    localparam int TDATA_W  = 32;

    typedef enum logic [1:0] {
        SEQ_IDLE,   // waiting for a pixel
        SEQ_WLO,    // lower bin write-back
        SEQ_WHI,    // upper bin write-back, next pixel may enter
        SEQ_DUMP    // streaming bins out and clearing them
    } seq_state_t;

    // dump read issued toward the output stage
    typedef struct packed {
        logic issue;
        logic last;
    } dump_req_t;

    // accumulator add, saturating at all ones
    function automatic logic [ACC_W-1:0] sat_add(
        input logic [ACC_W-1:0]  acc,
        input logic [PROD_W-1:0] amount
    );
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + (ACC_W+1)'(amount);
        return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/coh_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coh_bank
// Bin accumulator memory: one write port, two registered read ports.
// Read-first; per-entry valid bits make the bank read zero after reset.
// ----------------------------------------------------------------------------
module coh_bank #(
    parameter int NUM_BINS = 18
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(NUM_BINS)-1:0] wr_addr,
    input  wire logic [coh_pkg::ACC_W-1:0]   wr_data,
    input  wire logic                        rd_a_en,
    input  wire logic [$clog2(NUM_BINS)-1:0] rd_a_addr,
    output logic      [coh_pkg::ACC_W-1:0]   rd_a_data,
    input  wire logic                        rd_b_en,
    input  wire logic [$clog2(NUM_BINS)-1:0] rd_b_addr,
    output logic      [coh_pkg::ACC_W-1:0]   rd_b_data
);

    logic [coh_pkg::ACC_W-1:0] mem [NUM_BINS];
    logic [NUM_BINS-1:0]       valid_reg;
    logic [coh_pkg::ACC_W-1:0] rd_a_reg;
    logic [coh_pkg::ACC_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            rd_a_reg <= valid_reg[rd_a_addr] ? mem[rd_a_addr] : '0;
        end
        if (rd_b_en) begin
            rd_b_reg <= valid_reg[rd_b_addr] ? mem[rd_b_addr] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule
`default_nettype wire

FILE: rtl/coh_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coh_seq
// Read-modify-write sequencer: splits each pixel over two bins, updates the
// bank with forwarding, then sweeps the bank out and clears it on last pixel.
// ----------------------------------------------------------------------------
module coh_seq #(
    parameter int NUM_BINS = 18
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // pixel intake
    input  wire logic                         pix_valid,
    output logic                              pix_ready,
    input  wire logic [coh_pkg::MAG_W-1:0]    pix_magnitude,
    input  wire logic [coh_pkg::CODE_W-1:0]   pix_angle_code,
    input  wire logic                         pix_last,
    // output stage status
    input  wire logic                         out_hold,   // dump word still waiting
    input  wire logic                         dump_free,  // data register free next edge
    output coh_pkg::dump_req_t                dump,
    output logic      [$clog2(NUM_BINS)-1:0]  dump_idx,
    // bank
    output logic                              wr_en,
    output logic      [$clog2(NUM_BINS)-1:0]  wr_addr,
    output logic      [coh_pkg::ACC_W-1:0]    wr_data,
    output logic                              rd_a_en,
    output logic      [$clog2(NUM_BINS)-1:0]  rd_a_addr,
    input  wire logic [coh_pkg::ACC_W-1:0]    rd_a_data,
    output logic                              rd_b_en,
    output logic      [$clog2(NUM_BINS)-1:0]  rd_b_addr,
    input  wire logic [coh_pkg::ACC_W-1:0]    rd_b_data
);

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

    // coarse code to bin, reduced modulo NUM_BINS (constant mux)
    function automatic logic [AW-1:0] bin_wrap(input logic [coh_pkg::COARSE_W-1:0] c);
        logic [AW-1:0] r;
        logic [AW-1:0] res;
        r   = '0;
        res = '0;
        for (int i = 0; i < (1 << coh_pkg::COARSE_W); i++) begin
            if (c == coh_pkg::COARSE_W'(i)) begin
                res = r;
            end
            r = (r == LAST_BIN) ? '0 : r + AW'(1);
        end
        return res;
    endfunction

    coh_pkg::seq_state_t state_reg, state_next;

    logic [AW-1:0]                lo_reg, hi_reg;
    logic [coh_pkg::PROD_W-1:0]   wlo_reg, whi_reg;
    logic                         last_reg;
    logic                         fwd_lo_reg, fwd_hi_reg;
    logic [coh_pkg::ACC_W-1:0]    fwd_data_reg;
    logic [AW-1:0]                cnt_reg, cnt_next;

    logic                         accept;
    logic [AW-1:0]                lo_in, hi_in;
    logic [coh_pkg::FRAC_W-1:0]   frac_in;
    logic [coh_pkg::WGT_W-1:0]    wgt_lo_in;
    logic [coh_pkg::PROD_W-1:0]   wlo_in, whi_in;
    logic [coh_pkg::ACC_W-1:0]    base_lo, base_hi;
    logic                         issue;

    assign frac_in   = pix_angle_code[coh_pkg::FRAC_W-1:0];
    assign lo_in     = bin_wrap(pix_angle_code[coh_pkg::CODE_W-1:coh_pkg::FRAC_W]);
    assign hi_in     = (lo_in == LAST_BIN) ? '0 : lo_in + AW'(1);
    assign wgt_lo_in = coh_pkg::WGT_W'(1 << coh_pkg::FRAC_W) - coh_pkg::WGT_W'(frac_in);
    assign wlo_in    = pix_magnitude * wgt_lo_in;
    assign whi_in    = coh_pkg::PROD_W'(pix_magnitude) * coh_pkg::PROD_W'(frac_in);

    assign pix_ready = !out_hold &&
                       ((state_reg == coh_pkg::SEQ_IDLE) ||
                        (state_reg == coh_pkg::SEQ_WHI && !last_reg));
    assign accept    = pix_valid && pix_ready;

    // bin being written back in WHI may be read by the entering pixel
    assign base_lo = fwd_lo_reg ? fwd_data_reg : rd_a_data;
    assign base_hi = fwd_hi_reg ? fwd_data_reg : rd_b_data;

    assign issue      = (state_reg == coh_pkg::SEQ_DUMP) && dump_free;
    assign dump.issue = issue;
    assign dump.last  = (cnt_reg == LAST_BIN);
    assign dump_idx   = cnt_reg;

    assign rd_a_en   = accept || issue;
    assign rd_a_addr = (state_reg == coh_pkg::SEQ_DUMP) ? cnt_reg : lo_in;
    assign rd_b_en   = accept;
    assign rd_b_addr = hi_in;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wr_en      = 1'b0;
        wr_addr    = lo_reg;
        wr_data    = '0;
        unique case (state_reg)
            coh_pkg::SEQ_IDLE: begin
                if (accept) begin
                    state_next = coh_pkg::SEQ_WLO;
                end
            end
            coh_pkg::SEQ_WLO: begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg;
                wr_data    = coh_pkg::sat_add(base_lo, wlo_reg);
                state_next = coh_pkg::SEQ_WHI;
            end
            coh_pkg::SEQ_WHI: begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = coh_pkg::sat_add(base_hi, whi_reg);
                if (last_reg) begin
                    state_next = coh_pkg::SEQ_DUMP;
                    cnt_next   = '0;
                end else if (accept) begin
                    state_next = coh_pkg::SEQ_WLO;
                end else begin
                    state_next = coh_pkg::SEQ_IDLE;
                end
            end
            coh_pkg::SEQ_DUMP: begin
                if (issue) begin
                    // read-first bank: old value comes out, zero goes in
                    wr_en   = 1'b1;
                    wr_addr = cnt_reg;
                    wr_data = '0;
                    if (cnt_reg == LAST_BIN) begin
                        state_next = coh_pkg::SEQ_IDLE;
                    end else begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
            end
            default: begin
                state_next = coh_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= coh_pkg::SEQ_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lo_reg       <= lo_in;
            hi_reg       <= hi_in;
            wlo_reg      <= wlo_in;
            whi_reg      <= whi_in;
            last_reg     <= pix_last;
            fwd_lo_reg   <= (state_reg == coh_pkg::SEQ_WHI) && (lo_in == hi_reg);
            fwd_hi_reg   <= (state_reg == coh_pkg::SEQ_WHI) && (hi_in == hi_reg);
            fwd_data_reg <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cell_orientation_histogram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cell_orientation_histogram
// Orientation histogram of one gradient cell with linear bin interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   s_ side: one gradient pixel per word (magnitude, angle code), s_tlast on
//   the final pixel of a cell. The pixel weight is split between its lower
//   bin and the next bin (wrapping), with saturating accumulation.
//   m_ side: after the last pixel, NUM_BINS words in bin order, bin value in
//   m_tdata, bin number in m_tuser, m_tlast on the final bin.
// Timing:
//   A pixel takes the bank read of both bins, then the lower and upper
//   write-back, one per cycle on the single write port; the next pixel
//   enters during the upper write-back, with forwarding on a shared bin.
//   After a last pixel the bank is swept one bin per cycle unless the m_ side
//   stalls; each bin word goes from the bank read register to the output
//   register, and no pixel is taken until the sweep is done and the last word has left the read register.
// Reset clears control and the bank valid bits, so all bins read zero.
// A stalled m_ side holds the output word and one word in the bank read
// register; the sweep waits and no pixel is taken until it drains.
// ----------------------------------------------------------------------------
module cell_orientation_histogram #(
    parameter int NUM_BINS = 18
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // pixel stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [coh_pkg::TDATA_W-1:0]    s_tdata,   // [15:0] magnitude, [28:16] angle_code
    input  wire logic                           s_tlast,   // last_pixel
    // histogram stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [coh_pkg::TDATA_W-1:0]    m_tdata,   // [29:0] bin_value
    output logic      [coh_pkg::IDX_W-1:0]      m_tuser,   // [4:0] bin_index
    output logic                                m_tlast    // last_bin
);

    localparam int AW = $clog2(NUM_BINS);

    // bank wiring
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [coh_pkg::ACC_W-1:0]  wr_data;
    logic                       rd_a_en, rd_b_en;
    logic [AW-1:0]              rd_a_addr, rd_b_addr;
    logic [coh_pkg::ACC_W-1:0]  rd_a_data, rd_b_data;

    coh_pkg::dump_req_t         dreq;
    logic [AW-1:0]              dump_idx;

    // word sitting in the bank read register, waiting for the output register
    logic                       pend_reg;
    logic [AW-1:0]              pend_idx_reg;
    logic                       pend_last_reg;
    logic                       move;
    logic                       dump_free;

    // output register
    logic                       out_valid_reg;
    logic [coh_pkg::ACC_W-1:0]  out_value_reg;
    logic [coh_pkg::IDX_W-1:0]  out_index_reg;
    logic                       out_last_reg;

    coh_bank #(
        .NUM_BINS (NUM_BINS)
    ) u_bank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_en   (rd_a_en),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_en   (rd_b_en),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    coh_seq #(
        .NUM_BINS (NUM_BINS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pix_valid      (s_tvalid),
        .pix_ready      (s_tready),
        .pix_magnitude  (s_tdata[coh_pkg::MAG_W-1:0]),
        .pix_angle_code (s_tdata[coh_pkg::MAG_W +: coh_pkg::CODE_W]),
        .pix_last       (s_tlast),
        .out_hold       (pend_reg),
        .dump_free      (dump_free),
        .dump           (dreq),
        .dump_idx       (dump_idx),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_a_en        (rd_a_en),
        .rd_a_addr      (rd_a_addr),
        .rd_a_data      (rd_a_data),
        .rd_b_en        (rd_b_en),
        .rd_b_addr      (rd_b_addr),
        .rd_b_data      (rd_b_data)
    );

    // pending word moves on when the output register is empty or draining;
    // a new sweep read may land in the same edge the old word leaves
    assign move      = pend_reg && (!out_valid_reg || m_tready);
    assign dump_free = !pend_reg || move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (dreq.issue) begin
            pend_reg <= 1'b1;
        end else if (move) begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dreq.issue) begin
            pend_idx_reg  <= dump_idx;
            pend_last_reg <= dreq.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_value_reg <= rd_a_data;
            out_index_reg <= coh_pkg::IDX_W'(pend_idx_reg);
            out_last_reg  <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = coh_pkg::TDATA_W'(out_value_reg);
    assign m_tuser  = out_index_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // the final word of a histogram carries the top bin number
    a_last_index : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == coh_pkg::IDX_W'(NUM_BINS - 1)))
        else $error("last bin word carries wrong bin number");

    // the sweep and pixel intake share bank port A
    a_no_pixel_in_sweep : assert property (@(posedge aclk) disable iff (!aresetn)
        dreq.issue |-> !(s_tvalid && s_tready))
        else $error("pixel accepted during bank sweep");

    // a sweep read never overwrites a word still waiting in the read register
    a_sweep_room : assert property (@(posedge aclk) disable iff (!aresetn)
        (dreq.issue && pend_reg) |-> (!out_valid_reg || m_tready))
        else $error("sweep read issued over a pending word");

    // a moved word shows up on the output next cycle
    a_move_shows : assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> m_tvalid)
        else $error("moved word not presented");
`endif

endmodule
`default_nettype wire
